FILE: rtl/hsc_pkg.sv
// Shared constants, codes and controller/datapath handshake structs
// for the Hall speed block with sector calibration. No dependencies.
`timescale 1ns / 1ps
package hsc_pkg;

  localparam int SECTORS  = 6;
  localparam int SECT_W   = 3;
  localparam int CMD_W    = 2;
  localparam int HALL_W   = 3;
  localparam int PERIOD_W = 16;
  localparam int PP_W     = 8;
  localparam int SUM_W    = 26;
  localparam int FRAC_W   = 32;
  localparam int SPEED_W  = 27;
  localparam int PP6_W    = 11;
  localparam int Y_W      = PERIOD_W + PP6_W;
  localparam int NUM_W    = 62;
  localparam int DEN_W    = Y_W + 32;
  localparam int SHIFT_W  = SUM_W + 32;
  localparam int QUO_W    = 32;
  localparam int STEP_W   = 6;

  localparam int SAMPLES_PER_SECTOR_DEF = 100;

  localparam logic [FRAC_W-1:0]  DEFAULT_FRACTION = 32'd715827882;
  localparam logic [SPEED_W-1:0] SPEED_MAX        = 27'd120000000;
  localparam logic [29:0]        NUM_SCALE        = 30'd720000000;
  localparam logic [PP_W-1:0]    PP_ONE           = 8'd1;

  localparam logic [STEP_W-1:0] SPD_STEPS = 6'd27;
  localparam logic [STEP_W-1:0] FRC_STEPS = 6'd58;

  localparam logic [CMD_W-1:0] CMD_CAPTURE   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_OVERFLOW  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CALIBRATE = 2'd2;

  localparam logic [HALL_W-1:0] HALL_NONE_LO = 3'd0;
  localparam logic [HALL_W-1:0] HALL_NONE_HI = 3'd7;

  typedef enum logic [1:0] {
    PH_MEASURE = 2'd0,
    PH_COLLECT = 2'd1,
    PH_FINISH  = 2'd2
  } hsc_phase_t;

  typedef struct packed {
    logic latch;
    logic mul;
    logic speed_div_load;
    logic frac_div_load;
    logic div_step;
    logic speed_write;
    logic speed_zero;
    logic acc;
    logic cal_start;
    logic cal_end;
    logic measure;
    logic use_idx;
    logic idx_clear;
    logic idx_inc;
    logic frac_write;
    logic out_load;
  } hsc_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic             code_valid;
    hsc_phase_t       phase;
    logic             count_full;
    logic             total_zero;
    logic             idx_last;
    logic             div_last;
  } hsc_status_t;

endpackage

FILE: rtl/hsc_in_if.sv
// Input event channel: valid/ready handshake with command, Hall code and period.
// Depends on hsc_pkg for field widths.
`timescale 1ns / 1ps
interface hsc_in_if;
  logic                           valid;
  logic                           ready;
  logic [hsc_pkg::CMD_W-1:0]      command;
  logic [hsc_pkg::HALL_W-1:0]     hall_code;
  logic [hsc_pkg::PERIOD_W-1:0]   capture_period;

  modport source (output valid, output command, output hall_code,
                  output capture_period, input ready);
  modport sink   (input valid, input command, input hall_code,
                  input capture_period, output ready);
endinterface

FILE: rtl/hsc_out_if.sv
// Result channel: valid/ready handshake with speed and calibration phase.
// Depends on hsc_pkg for field widths.
`timescale 1ns / 1ps
interface hsc_out_if;
  logic                          valid;
  logic                          ready;
  logic [hsc_pkg::SPEED_W-1:0]   speed;
  logic [1:0]                    cal_phase;

  modport source (output valid, output speed, output cal_phase, input ready);
  modport sink   (input valid, input speed, input cal_phase, output ready);
endinterface

FILE: rtl/hsc_datapath.sv
// Datapath: item registers, sector sum and fraction stores, calibration
// state, shared restoring divider and result register. Depends on hsc_pkg.
`timescale 1ns / 1ps
module hsc_datapath #(
  parameter int SAMPLES_PER_SECTOR = hsc_pkg::SAMPLES_PER_SECTOR_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  hsc_pkg::hsc_cmd_t             cmd,
  output hsc_pkg::hsc_status_t          status,
  input  logic [hsc_pkg::CMD_W-1:0]     command,
  input  logic [hsc_pkg::HALL_W-1:0]    hall_code,
  input  logic [hsc_pkg::PERIOD_W-1:0]  capture_period,
  input  logic                          pole_pairs_we,
  input  logic [hsc_pkg::PP_W-1:0]      pole_pairs_wdata,
  output logic [hsc_pkg::SPEED_W-1:0]   speed,
  output logic [1:0]                    cal_phase
);
  import hsc_pkg::*;

  localparam int SAMPLE_LIMIT = SECTORS * SAMPLES_PER_SECTOR;
  localparam int CNT_W        = $clog2(SAMPLE_LIMIT + 1);
  localparam logic [CNT_W-1:0]  CNT_LIMIT = CNT_W'(SAMPLE_LIMIT);
  localparam logic [SECT_W-1:0] IDX_LAST  = SECT_W'(SECTORS - 1);

  logic [CMD_W-1:0]    item_cmd;
  logic [HALL_W-1:0]   item_code;
  logic [PERIOD_W-1:0] item_period;
  logic [SECT_W-1:0]   item_sector;

  logic [PP_W-1:0]     pole_pairs;
  logic [PP_W-1:0]     pp_eff;
  logic [PP6_W-1:0]    pp6;

  hsc_phase_t          phase;
  logic [CNT_W-1:0]    sample_count;
  logic [SUM_W-1:0]    total_sum;
  logic [SPEED_W-1:0]  speed_reg;
  logic [SECT_W-1:0]   idx;

  logic [SUM_W-1:0]    sum_mem [SECTORS];
  logic [SECTORS-1:0]  sum_valid;
  logic [SUM_W-1:0]    sum_rd;
  logic [SECT_W-1:0]   sum_addr;

  logic [FRAC_W-1:0]   frac_mem [SECTORS];
  logic [SECTORS-1:0]  frac_valid;
  logic [FRAC_W-1:0]   frac_rd;

  logic [NUM_W-1:0]    num_reg;
  logic [Y_W-1:0]      y_reg;
  logic [DEN_W-1:0]    den_reg;
  logic [DEN_W-1:0]    rem;
  logic [SHIFT_W-1:0]  sh;
  logic [QUO_W-1:0]    quo;
  logic [STEP_W-1:0]   steps;

  logic [DEN_W:0]      trial;
  logic [DEN_W:0]      diff;
  logic                ge;
  logic [SHIFT_W-1:0]  frac_num;

  logic [SPEED_W-1:0]  out_speed;
  hsc_phase_t          out_phase;

  assign item_sector = item_code - 3'd1;
  assign sum_addr    = cmd.use_idx ? idx : item_sector;
  assign pp_eff      = (pole_pairs == '0) ? PP_ONE : pole_pairs;
  assign pp6         = {1'b0, pp_eff, 2'b00} + {2'b00, pp_eff, 1'b0};

  assign trial    = {rem, sh[SHIFT_W-1]};
  assign diff     = trial - {1'b0, den_reg};
  assign ge       = trial >= {1'b0, den_reg};
  assign frac_num = {sum_rd, 32'b0} - {32'b0, sum_rd};

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item_cmd    <= command;
      item_code   <= hall_code;
      item_period <= capture_period;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pole_pairs <= PP_ONE;
    end else if (pole_pairs_we) begin
      pole_pairs <= pole_pairs_wdata;
    end
  end

  // sector sum store
  always_ff @(posedge clk) begin
    if (cmd.acc) begin
      sum_mem[item_sector] <= sum_rd + SUM_W'(item_period);
    end
    sum_rd <= sum_valid[sum_addr] ? sum_mem[sum_addr] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.cal_start) begin
      sum_valid <= '0;
    end else if (cmd.acc) begin
      sum_valid[item_sector] <= 1'b1;
    end
  end

  // sector fraction store
  always_ff @(posedge clk) begin
    if (cmd.frac_write) begin
      frac_mem[idx] <= quo;
    end
    frac_rd <= frac_valid[item_sector] ? frac_mem[item_sector] : DEFAULT_FRACTION;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frac_valid <= '0;
    end else if (cmd.frac_write) begin
      frac_valid[idx] <= 1'b1;
    end
  end

  // calibration and speed state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_MEASURE;
      sample_count <= '0;
      total_sum    <= '0;
      speed_reg    <= '0;
      idx          <= '0;
    end else begin
      if (cmd.cal_start) begin
        phase        <= PH_COLLECT;
        sample_count <= '0;
        total_sum    <= '0;
      end else if (cmd.cal_end) begin
        phase        <= PH_FINISH;
        sample_count <= '0;
      end else if (cmd.measure) begin
        phase <= PH_MEASURE;
      end else if (cmd.acc) begin
        sample_count <= sample_count + CNT_W'(1);
        total_sum    <= total_sum + SUM_W'(item_period);
      end
      if (cmd.speed_zero) begin
        speed_reg <= '0;
      end else if (cmd.speed_write) begin
        speed_reg <= (item_period == '0) ? SPEED_MAX : quo[SPEED_W-1:0];
      end
      if (cmd.idx_clear) begin
        idx <= '0;
      end else if (cmd.idx_inc) begin
        idx <= idx + SECT_W'(1);
      end
    end
  end

  // restoring divider, one quotient bit per step
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      num_reg <= {30'b0, frac_rd} * {32'b0, NUM_SCALE};
      y_reg   <= {{PP6_W{1'b0}}, item_period} * {{PERIOD_W{1'b0}}, pp6};
    end
    if (cmd.speed_div_load) begin
      den_reg <= {y_reg, 32'b0} - {32'b0, y_reg};
      rem     <= {{(DEN_W - 35){1'b0}}, num_reg[NUM_W-1:27]};
      sh      <= {num_reg[26:0], {(SHIFT_W - 27){1'b0}}};
      steps   <= SPD_STEPS;
    end else if (cmd.frac_div_load) begin
      den_reg <= {{(DEN_W - SUM_W){1'b0}}, total_sum};
      rem     <= '0;
      sh      <= frac_num;
      steps   <= FRC_STEPS;
    end else if (cmd.div_step) begin
      rem   <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      sh    <= {sh[SHIFT_W-2:0], 1'b0};
      quo   <= {quo[QUO_W-2:0], ge};
      steps <= steps - STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_speed <= speed_reg;
      out_phase <= phase;
    end
  end

  assign speed     = out_speed;
  assign cal_phase = out_phase;

  assign status.command    = item_cmd;
  assign status.code_valid = (item_code != HALL_NONE_LO) && (item_code != HALL_NONE_HI);
  assign status.phase      = phase;
  assign status.count_full = sample_count >= CNT_LIMIT;
  assign status.total_zero = total_sum == '0;
  assign status.idx_last   = idx == IDX_LAST;
  assign status.div_last   = steps == 6'd1;

  a_speed_bound: assert property (@(posedge clk) disable iff (rst)
    speed_reg <= SPEED_MAX)
    else $error("speed register above full scale");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    sample_count <= CNT_LIMIT)
    else $error("sample count past limit");

  a_cal_start: assert property (@(posedge clk) disable iff (rst)
    cmd.cal_start |=> (phase == PH_COLLECT) && (sample_count == '0) && (total_sum == '0))
    else $error("calibration start did not clear state");

endmodule

FILE: rtl/hsc_controller.sv
// Controller FSM: sequences each item through the datapath and drives the
// input and result handshakes. Depends on hsc_pkg.
`timescale 1ns / 1ps
module hsc_controller (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  hsc_pkg::hsc_status_t  status,
  output hsc_pkg::hsc_cmd_t     cmd
);
  import hsc_pkg::*;

  typedef enum logic [11:0] {
    ST_IDLE    = 12'b0000_0000_0001,
    ST_DECODE  = 12'b0000_0000_0010,
    ST_MUL     = 12'b0000_0000_0100,
    ST_DEN     = 12'b0000_0000_1000,
    ST_DIV_SPD = 12'b0000_0001_0000,
    ST_SPD_WR  = 12'b0000_0010_0000,
    ST_ACC     = 12'b0000_0100_0000,
    ST_CRD     = 12'b0000_1000_0000,
    ST_CLD     = 12'b0001_0000_0000,
    ST_DIV_FRC = 12'b0010_0000_0000,
    ST_FWR     = 12'b0100_0000_0000,
    ST_OUT     = 12'b1000_0000_0000
  } hsc_state_t;

  hsc_state_t state;
  hsc_state_t state_next;
  logic       out_free;

  assign in_ready = state == ST_IDLE;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_next = ST_OUT;
        if (status.command == CMD_CAPTURE && status.code_valid) begin
          unique case (status.phase)
            PH_MEASURE: state_next = ST_MUL;
            PH_COLLECT: begin
              if (status.count_full) begin
                cmd.cal_end = 1'b1;
              end else begin
                state_next = ST_ACC;
              end
            end
            PH_FINISH: begin
              if (status.total_zero) begin
                cmd.measure = 1'b1;
              end else begin
                cmd.idx_clear = 1'b1;
                state_next    = ST_CRD;
              end
            end
            default: cmd.measure = 1'b1;
          endcase
        end else if (status.command == CMD_OVERFLOW) begin
          cmd.speed_zero = 1'b1;
        end else if (status.command == CMD_CALIBRATE) begin
          cmd.cal_start = 1'b1;
        end
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_DEN;
      end
      ST_DEN: begin
        cmd.speed_div_load = 1'b1;
        state_next         = ST_DIV_SPD;
      end
      ST_DIV_SPD: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = ST_SPD_WR;
        end
      end
      ST_SPD_WR: begin
        cmd.speed_write = 1'b1;
        state_next      = ST_OUT;
      end
      ST_ACC: begin
        cmd.acc    = 1'b1;
        state_next = ST_OUT;
      end
      ST_CRD: begin
        cmd.use_idx = 1'b1;
        state_next  = ST_CLD;
      end
      ST_CLD: begin
        cmd.frac_div_load = 1'b1;
        state_next        = ST_DIV_FRC;
      end
      ST_DIV_FRC: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = ST_FWR;
        end
      end
      ST_FWR: begin
        cmd.frac_write = 1'b1;
        if (status.idx_last) begin
          cmd.measure = 1'b1;
          state_next  = ST_OUT;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = ST_CRD;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> out_free)
    else $error("result register overwritten while full");

endmodule

FILE: rtl/hall_speed_with_sector_calibration.sv
// Top level: Hall speed measurement with per-sector calibration.
// Depends on hsc_pkg, hsc_in_if, hsc_out_if, hsc_controller, hsc_datapath.
//
//   port              dir   contents
//   request           sink  command, hall_code, capture_period
//   result            src   speed, cal_phase
//   pole_pairs_we/..  in    pole pair count register write
//
// Capture while measuring: speed is set by the 27-step restoring divider.
// Capture finishing calibration: six 58-step divisions, one per sector.
// Capture while collecting: adds the period to its sector sum. One item at
// a time; the next is accepted once the result sits in the output register,
// even if that result is not yet taken.
// Reset (rst, synchronous) restores phase, sums, fractions and pole pairs.
`timescale 1ns / 1ps
module hall_speed_with_sector_calibration #(
  parameter int SAMPLES_PER_SECTOR = hsc_pkg::SAMPLES_PER_SECTOR_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  hsc_in_if.sink                    request,
  hsc_out_if.source                 result,
  input  logic                      pole_pairs_we,
  input  logic [hsc_pkg::PP_W-1:0]  pole_pairs_wdata
);
  import hsc_pkg::*;

  hsc_cmd_t    cmd;
  hsc_status_t status;

  hsc_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (request.valid),
    .in_ready  (request.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .status    (status),
    .cmd       (cmd)
  );

  hsc_datapath #(
    .SAMPLES_PER_SECTOR (SAMPLES_PER_SECTOR)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .command          (request.command),
    .hall_code        (request.hall_code),
    .capture_period   (request.capture_period),
    .pole_pairs_we    (pole_pairs_we),
    .pole_pairs_wdata (pole_pairs_wdata),
    .speed            (result.speed),
    .cal_phase        (result.cal_phase)
  );

endmodule
